// ----- design/page_framebuffer_rect_fill_unit_defines.svh -----
// Assertion macros shared by the frame fill unit modules.
// They expect clk and rst_n in scope.
`ifndef PAGE_FRAMEBUFFER_RECT_FILL_UNIT_DEFINES_SVH
`define PAGE_FRAMEBUFFER_RECT_FILL_UNIT_DEFINES_SVH

// Same-cycle implication.
`define PFRF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfrf: same-cycle check failed");

// Next-cycle implication.
`define PFRF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfrf: next-cycle check failed");

`endif

// ----- design/pfrf_pkg.sv -----
`timescale 1ns / 1ps

package pfrf_pkg;

  localparam int unsigned COORD_W    = 8;
  localparam int unsigned PAGE_W     = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned OUT_PAGE_W = 3;
  localparam int unsigned OUT_COL_W  = 7;

  localparam logic [BYTE_W-1:0] BYTE_ONES = 8'hff;

  typedef enum logic [1:0] {
    OP_FILL   = 2'd0,
    OP_ERASE  = 2'd1,
    OP_INVERT = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_SWEEP,
    S_FLUSH,
    S_READ,
    S_RDOUT
  } state_t;

  typedef struct packed {
    logic load;
    logic clr_step;
    logic rd_issue;
    logic next_page;
    logic emit_flush;
    logic emit_read;
  } cmd_t;

  typedef struct packed {
    logic clr_done;
    logic in_read;
    logic in_empty;
    logic col_last;
    logic page_last;
    logic out_busy;
  } sts_t;

endpackage

// ----- design/pfrf_ctrl.sv -----
`timescale 1ns / 1ps
`include "page_framebuffer_rect_fill_unit_defines.svh"

module pfrf_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  pfrf_pkg::sts_t sts,
  output pfrf_pkg::cmd_t cmd
);

  pfrf_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= pfrf_pkg::S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    unique case (state_r)
      pfrf_pkg::S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = pfrf_pkg::S_IDLE;
        end
      end
      pfrf_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.load = 1'b1;
          priority if (sts.in_read) begin
            state_nxt = pfrf_pkg::S_READ;
          end else if (sts.in_empty) begin
            state_nxt = pfrf_pkg::S_IDLE;
          end else begin
            state_nxt = pfrf_pkg::S_SWEEP;
          end
        end
      end
      pfrf_pkg::S_SWEEP: begin
        cmd.rd_issue = 1'b1;
        if (sts.col_last) begin
          state_nxt = pfrf_pkg::S_FLUSH;
        end
      end
      pfrf_pkg::S_FLUSH: begin
        if (!sts.out_busy) begin
          cmd.emit_flush = 1'b1;
          if (sts.page_last) begin
            state_nxt = pfrf_pkg::S_IDLE;
          end else begin
            cmd.next_page = 1'b1;
            state_nxt     = pfrf_pkg::S_SWEEP;
          end
        end
      end
      pfrf_pkg::S_READ: begin
        cmd.rd_issue = 1'b1;
        state_nxt    = pfrf_pkg::S_RDOUT;
      end
      pfrf_pkg::S_RDOUT: begin
        if (!sts.out_busy) begin
          cmd.emit_read = 1'b1;
          state_nxt     = pfrf_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pfrf_pkg::S_CLEAR;
      end
    endcase
  end

  `PFRF_ASSERT_IMP(a_emit_when_free, cmd.emit_flush || cmd.emit_read, !sts.out_busy)
  `PFRF_ASSERT_IMP(a_issue_after_clear, cmd.rd_issue, sts.clr_done)
  `PFRF_ASSERT_NXT(a_last_flush_idle, cmd.emit_flush && sts.page_last,
                   state_r == pfrf_pkg::S_IDLE)

endmodule

// ----- design/pfrf_dp.sv -----
`timescale 1ns / 1ps
`include "page_framebuffer_rect_fill_unit_defines.svh"

module pfrf_dp #(
  parameter int unsigned WIDTH  = 128,
  parameter int unsigned HEIGHT = 64
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  pfrf_pkg::cmd_t                       cmd,
  output pfrf_pkg::sts_t                       sts,
  input  logic [1:0]                           in_op,
  input  logic [pfrf_pkg::COORD_W-1:0]         in_left_col,
  input  logic [pfrf_pkg::COORD_W-1:0]         in_top_row,
  input  logic [pfrf_pkg::COORD_W-1:0]         in_right_col,
  input  logic [pfrf_pkg::COORD_W-1:0]         in_bottom_row,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output logic [pfrf_pkg::OUT_PAGE_W-1:0]      out_page_index,
  output logic [pfrf_pkg::OUT_COL_W-1:0]       out_from_column,
  output logic [pfrf_pkg::OUT_COL_W-1:0]       out_to_column,
  output logic [pfrf_pkg::BYTE_W-1:0]          out_read_byte,
  output logic                                 out_last
);

  localparam int unsigned PAGES      = (HEIGHT + 7) / 8;
  localparam int unsigned STORE_SIZE = WIDTH * PAGES;
  localparam int unsigned ADDR_W     = $clog2(STORE_SIZE);
  localparam int unsigned PROD_W     = pfrf_pkg::PAGE_W + pfrf_pkg::COORD_W;
  localparam int unsigned CW         = pfrf_pkg::COORD_W;
  localparam int unsigned PW         = pfrf_pkg::PAGE_W;
  localparam int unsigned BW         = pfrf_pkg::BYTE_W;
  localparam int unsigned OPW        = pfrf_pkg::OUT_PAGE_W;
  localparam int unsigned OCW        = pfrf_pkg::OUT_COL_W;
  localparam logic [CW-1:0]     MAX_COL  = CW'(WIDTH - 1);
  localparam logic [CW-1:0]     MAX_ROW  = CW'(HEIGHT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(STORE_SIZE - 1);
  localparam logic [ADDR_W-1:0] PAGE_STEP = ADDR_W'(WIDTH);

  // Decode of the incoming item (used only on load)
  pfrf_pkg::op_t   in_op_c;
  logic            is_read_c;
  logic [CW-1:0]   x1_c, y1_c, x2_c, y2_c;
  logic [PW-1:0]   p1_c;
  logic [PROD_W-1:0] prod_c;

  assign in_op_c   = pfrf_pkg::op_t'(in_op);
  assign is_read_c = (in_op_c == pfrf_pkg::OP_READ);
  assign x1_c = (is_read_c && (in_left_col > MAX_COL)) ? MAX_COL : in_left_col;
  assign y1_c = (is_read_c && (in_top_row > MAX_ROW)) ? MAX_ROW : in_top_row;
  assign x2_c = (in_right_col > MAX_COL) ? MAX_COL : in_right_col;
  assign y2_c = (in_bottom_row > MAX_ROW) ? MAX_ROW : in_bottom_row;
  assign p1_c = y1_c[CW-1:3];
  assign prod_c = PROD_W'(p1_c) * PROD_W'(WIDTH);

  // Command registers
  pfrf_pkg::op_t   op_r;
  logic [CW-1:0]   x1_r, x2_r, col_r;
  logic [PW-1:0]   page_r, p1_r, p2_r;
  logic [2:0]      y1lo_r, y2lo_r;
  logic [ADDR_W-1:0] base_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op_c;
      x1_r   <= x1_c;
      x2_r   <= x2_c;
      col_r  <= x1_c;
      page_r <= p1_c;
      p1_r   <= p1_c;
      p2_r   <= y2_c[CW-1:3];
      y1lo_r <= y1_c[2:0];
      y2lo_r <= y2_c[2:0];
      base_r <= prod_c[ADDR_W-1:0];
    end else if (cmd.next_page) begin
      page_r <= page_r + PW'(1);
      base_r <= base_r + PAGE_STEP;
      col_r  <= x1_r;
    end else if (cmd.rd_issue) begin
      col_r  <= col_r + CW'(1);
    end
  end

  // Page mask: partial top and bottom pages
  logic [BW-1:0]     top_m_c, bot_m_c, mask_c;
  logic [ADDR_W-1:0] rd_addr_c;

  assign top_m_c = pfrf_pkg::BYTE_ONES << y1lo_r;
  assign bot_m_c = pfrf_pkg::BYTE_ONES >> (3'd7 - y2lo_r);
  assign mask_c  = ((page_r == p1_r) ? top_m_c : pfrf_pkg::BYTE_ONES) &
                   ((page_r == p2_r) ? bot_m_c : pfrf_pkg::BYTE_ONES);
  assign rd_addr_c = base_r + ADDR_W'(col_r);

  // Read-modify-write pipeline: read at issue, write back in the cycle after
  logic              wr_en_r;
  logic [ADDR_W-1:0] wr_addr_r;
  logic [BW-1:0]     wr_mask_r;
  logic [BW-1:0]     rdata_r;
  logic [BW-1:0]     wdata_c;
  logic [ADDR_W-1:0] clr_addr_r;
  logic [BW-1:0]     frame_mem_r [STORE_SIZE];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_en_r    <= 1'b0;
      clr_addr_r <= '0;
    end else begin
      wr_en_r <= cmd.rd_issue && (op_r != pfrf_pkg::OP_READ);
      if (cmd.clr_step && (clr_addr_r != LAST_ADDR)) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      wr_addr_r <= rd_addr_c;
      wr_mask_r <= mask_c;
    end
  end

  always_comb begin
    unique case (op_r)
      pfrf_pkg::OP_FILL:   wdata_c = rdata_r | wr_mask_r;
      pfrf_pkg::OP_ERASE:  wdata_c = rdata_r & ~wr_mask_r;
      pfrf_pkg::OP_INVERT: wdata_c = rdata_r ^ wr_mask_r;
      pfrf_pkg::OP_READ:   wdata_c = rdata_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      rdata_r <= frame_mem_r[rd_addr_c];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_step) begin
      frame_mem_r[clr_addr_r] <= '0;
    end else if (wr_en_r) begin
      frame_mem_r[wr_addr_r] <= wdata_c;
    end
  end

  // Output register
  logic            out_valid_r;
  logic [OPW-1:0]  out_page_r;
  logic [OCW-1:0]  out_from_r, out_to_r;
  logic [BW-1:0]   out_byte_r;
  logic            out_last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit_flush || cmd.emit_read) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_flush) begin
      out_page_r <= page_r[OPW-1:0];
      out_from_r <= x1_r[OCW-1:0];
      out_to_r   <= x2_r[OCW-1:0];
      out_byte_r <= '0;
      out_last_r <= (page_r == p2_r);
    end else if (cmd.emit_read) begin
      out_page_r <= page_r[OPW-1:0];
      out_from_r <= x1_r[OCW-1:0];
      out_to_r   <= x1_r[OCW-1:0];
      out_byte_r <= rdata_r;
      out_last_r <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_page_index  = out_page_r;
  assign out_from_column = out_from_r;
  assign out_to_column   = out_to_r;
  assign out_read_byte   = out_byte_r;
  assign out_last        = out_last_r;

  // Status to the controller
  always_comb begin
    sts.clr_done  = (clr_addr_r == LAST_ADDR);
    sts.in_read   = is_read_c;
    sts.in_empty  = (in_left_col > x2_c) || (in_top_row > y2_c);
    sts.col_last  = (col_r == x2_r);
    sts.page_last = (page_r == p2_r);
    sts.out_busy  = out_valid_r && out_stall;
  end

  `PFRF_ASSERT_IMP(a_wr_in_range, wr_en_r, wr_addr_r <= LAST_ADDR)
  `PFRF_ASSERT_IMP(a_no_clr_during_write, cmd.clr_step, !wr_en_r)
  `PFRF_ASSERT_NXT(a_emit_sets_valid, cmd.emit_flush || cmd.emit_read, out_valid_r)

endmodule

// ----- design/page_framebuffer_rect_fill_unit.sv -----
`timescale 1ns / 1ps
// Rectangle op: the item is taken, then for each page touched one read-modify-write per
//   column and one flush of its span, which waits while out_stall holds the output.
// Read op: the byte is read in S_READ, registered in S_RDOUT. Empty rectangle: no result.
// One item at a time; the store's single write port sets the pace (one byte per cycle
//   during a page sweep). Reset: after rst_n the WIDTH*ceil(HEIGHT/8) store bytes (1024
//   by default) are cleared at one byte per cycle, with in_stall held high.

module page_framebuffer_rect_fill_unit #(
  parameter int unsigned WIDTH  = 128,  // columns, 8..128
  parameter int unsigned HEIGHT = 64    // pixel rows, 8..64
) (
  input  logic       clk,
  input  logic       rst_n,
  // command items
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_op,
  input  logic [7:0] in_left_col,
  input  logic [7:0] in_top_row,
  input  logic [7:0] in_right_col,
  input  logic [7:0] in_bottom_row,
  // result items (flush spans, read data)
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] out_page_index,
  output logic [6:0] out_from_column,
  output logic [6:0] out_to_column,
  output logic [7:0] out_read_byte,
  output logic       out_last
);

  // Controller <-> datapath
  pfrf_pkg::cmd_t cmd;
  pfrf_pkg::sts_t sts;

  // Sequencer: clear pass, column sweep per page, flush and read results.
  pfrf_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Frame store, clamp and mask logic, RMW pipeline and output register.
  // An item can be taken while a result still waits in the output register.
  pfrf_dp #(
    .WIDTH  (WIDTH),
    .HEIGHT (HEIGHT)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .in_op           (in_op),
    .in_left_col     (in_left_col),
    .in_top_row      (in_top_row),
    .in_right_col    (in_right_col),
    .in_bottom_row   (in_bottom_row),
    .out_stall       (out_stall),
    .out_valid       (out_valid),
    .out_page_index  (out_page_index),
    .out_from_column (out_from_column),
    .out_to_column   (out_to_column),
    .out_read_byte   (out_read_byte),
    .out_last        (out_last)
  );

endmodule
